### hdl/sam_pkg.sv
package sam_pkg;

  localparam int DEF_MAX_TEXT  = 1024;
  localparam int DEF_MAX_NODES = 2048;
  localparam int DEF_ALPHABET  = 26;

  localparam int SYM_W = 5;
  localparam int LEN_W = 11;
  localparam int CNT_W = 20;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_MATCH  = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ROOT_CLR,
    CMD_REFUSE,
    CMD_APP_INIT,
    CMD_CLR,
    CMD_SETU,
    CMD_WRD,
    CMD_WEV,
    CMD_CKRD,
    CMD_CKEV,
    CMD_COPY,
    CMD_RRD,
    CMD_REV,
    CMD_LNKQ,
    CMD_LNKU,
    CMD_FIN,
    CMD_M_INIT,
    CMD_MRD,
    CMD_MEV
  } cmd_t;

  typedef struct packed {
    logic op;
    logic sym_ok;
    logic cap_full;
    logic k_last;
    logic k_end;
    logic hit;
    logic p_root;
    logic solid;
    logic same;
  } sam_stat_t;

endpackage

### hdl/sam_ctrl.sv
module sam_ctrl
  import sam_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  sam_stat_t stat,
  output logic      busy,
  output logic      done,
  output cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_RCLR, S_IDLE, S_DISP, S_CLR, S_SETU, S_WRD, S_WEV, S_CKRD, S_CKEV,
    S_COPY, S_RRD, S_REV, S_LNKQ, S_LNKU, S_FIN, S_MRD, S_MEV
  } state_t;

  state_t state, state_next;
  logic   fin;

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    fin        = 1'b0;
    case (state)
      S_RCLR: begin
        cmd = CMD_ROOT_CLR;
        if (stat.k_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd        = CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.op == OP_APPEND) begin
          if (!stat.sym_ok) begin
            fin = 1'b1;
          end else if (stat.cap_full) begin
            cmd = CMD_REFUSE;
            fin = 1'b1;
          end else begin
            cmd        = CMD_APP_INIT;
            state_next = S_CLR;
          end
        end else begin
          cmd = CMD_M_INIT;
          if (!stat.sym_ok) fin = 1'b1;
          else state_next = S_MRD;
        end
      end
      S_CLR: begin
        cmd = CMD_CLR;
        if (stat.k_last) state_next = S_SETU;
      end
      S_SETU: begin
        cmd        = CMD_SETU;
        state_next = S_WRD;
      end
      S_WRD: begin
        cmd        = CMD_WRD;
        state_next = S_WEV;
      end
      S_WEV: begin
        cmd = CMD_WEV;
        if (stat.hit) state_next = S_CKRD;
        else if (stat.p_root) state_next = S_FIN;
        else state_next = S_WRD;
      end
      S_CKRD: begin
        cmd        = CMD_CKRD;
        state_next = S_CKEV;
      end
      S_CKEV: begin
        cmd        = CMD_CKEV;
        state_next = stat.solid ? S_FIN : S_COPY;
      end
      S_COPY: begin
        cmd = CMD_COPY;
        if (stat.k_end) state_next = S_RRD;
      end
      S_RRD: begin
        cmd        = CMD_RRD;
        state_next = S_REV;
      end
      S_REV: begin
        cmd = CMD_REV;
        if (!stat.same || stat.p_root) state_next = S_LNKQ;
        else state_next = S_RRD;
      end
      S_LNKQ: begin
        cmd        = CMD_LNKQ;
        state_next = S_LNKU;
      end
      S_LNKU: begin
        cmd        = CMD_LNKU;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd = CMD_FIN;
        fin = 1'b1;
      end
      S_MRD: begin
        cmd        = CMD_MRD;
        state_next = S_MEV;
      end
      S_MEV: begin
        cmd = CMD_MEV;
        if (stat.hit || stat.p_root) fin = 1'b1;
        else state_next = S_MRD;
      end
      default: state_next = S_IDLE;
    endcase
    if (fin) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

### hdl/sam_dpath.sv
module sam_dpath
  import sam_pkg::*;
#(
  parameter int MAX_TEXT  = DEF_MAX_TEXT,
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int ALPHABET  = DEF_ALPHABET
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             op,
  input  logic [SYM_W-1:0] symbol,
  input  logic             restart,
  output sam_stat_t        stat,
  output logic [LEN_W-1:0] matched_len,
  output logic [LEN_W-1:0] best_len,
  output logic             contained,
  output logic [CNT_W-1:0] distinct_count,
  output logic             overflow
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int TW    = $clog2(MAX_TEXT + 1);
  localparam int DEPTH = MAX_NODES * ALPHABET;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(ALPHABET + 1);

  logic [NW-1:0] trans_mem [DEPTH];
  logic [NW-1:0] link_mem  [MAX_NODES];
  logic [TW-1:0] len_mem   [MAX_NODES];

  logic [NW-1:0] trans_q, link_q;
  logic [TW-1:0] len_q;

  logic             op_r, rs_r;
  logic [SYM_W-1:0] sym_r;
  logic             ovf;
  logic [CW-1:0]    ncount;
  logic [TW-1:0]    tlen;
  logic [CNT_W-1:0] dcount;
  logic [NW-1:0]    last, u, row_r, p, q, cl;
  logic [KW-1:0]    k;
  logic [TW-1:0]    lenu, lenp, lenlink;
  logic [NW-1:0]    mnode;
  logic [LEN_W-1:0] mlen, mbest, new_len;
  logic             alive, first;

  logic [AW-1:0] t_ra, t_wa;
  logic [NW-1:0] t_wd, l_ra, l_wa, l_wd, n_ra, n_wa;
  logic [TW-1:0] n_wd;
  logic          t_we, l_we, n_we;
  logic [TW:0]   lenq_p1;
  logic [CNT_W:0] dsum;
  logic [NW-1:0] nc_node;

  function automatic logic [AW-1:0] addr(input logic [NW-1:0] n, input logic [AW-1:0] off);
    return AW'(n) * AW'(ALPHABET) + off;
  endfunction

  assign nc_node = ncount[NW-1:0];
  assign lenq_p1 = {1'b0, len_q} + (TW+1)'(1);
  assign dsum    = {1'b0, dcount} + (CNT_W+1)'(lenu - lenlink);

  assign stat.op       = op_r;
  assign stat.sym_ok   = (32'(sym_r) < ALPHABET);
  assign stat.cap_full = (tlen >= TW'(MAX_TEXT)) || (ncount > CW'(MAX_NODES - 2));
  assign stat.k_last   = (k == KW'(ALPHABET - 1));
  assign stat.k_end    = (k == KW'(ALPHABET));
  assign stat.hit      = (trans_q != '0);
  assign stat.p_root   = (p == '0);
  assign stat.solid    = ({1'b0, lenp} + (TW+1)'(1)) == {1'b0, len_q};
  assign stat.same     = (trans_q == q);

  // read address selection
  always_comb begin
    t_ra = addr(p, AW'(sym_r));
    l_ra = p;
    n_ra = p;
    case (cmd)
      CMD_COPY:               t_ra = addr(q, AW'(k));
      CMD_CKRD: begin
        l_ra = q;
        n_ra = q;
      end
      CMD_APP_INIT, CMD_CLR:  n_ra = last;
      default: ;
    endcase
  end

  // write port selection
  always_comb begin
    t_we = 1'b0;
    t_wa = addr(p, AW'(sym_r));
    t_wd = '0;
    l_we = 1'b0;
    l_wa = u;
    l_wd = '0;
    n_we = 1'b0;
    n_wa = u;
    n_wd = '0;
    case (cmd)
      CMD_ROOT_CLR, CMD_CLR: begin
        t_we = 1'b1;
        t_wa = addr(row_r, AW'(k));
        if (cmd == CMD_ROOT_CLR) begin
          n_we = 1'b1;
          n_wa = '0;
        end
      end
      CMD_SETU: begin
        n_we = 1'b1;
        n_wd = len_q + TW'(1);
        l_we = 1'b1;
      end
      CMD_WEV: begin
        t_we = !stat.hit;
        t_wd = u;
      end
      CMD_CKEV: begin
        l_we = 1'b1;
        if (stat.solid) begin
          l_wd = q;
        end else begin
          l_wa = nc_node;
          l_wd = link_q;
          n_we = 1'b1;
          n_wa = nc_node;
          n_wd = lenp + TW'(1);
        end
      end
      CMD_COPY: begin
        t_we = (k != '0);
        t_wa = addr(cl, AW'(k - KW'(1)));
        t_wd = trans_q;
      end
      CMD_REV: begin
        t_we = stat.same;
        t_wd = cl;
      end
      CMD_LNKQ: begin
        l_we = 1'b1;
        l_wa = q;
        l_wd = cl;
      end
      CMD_LNKU: begin
        l_we = 1'b1;
        l_wd = cl;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) trans_mem[t_wa] <= t_wd;
    if (l_we) link_mem[l_wa] <= l_wd;
    if (n_we) len_mem[n_wa] <= n_wd;
    trans_q <= trans_mem[t_ra];
    link_q  <= link_mem[l_ra];
    len_q   <= len_mem[n_ra];
  end

  // match length after a hit
  always_comb begin
    if (first) begin
      new_len = (mlen != LEN_MAX) ? mlen + LEN_W'(1) : LEN_MAX;
    end else if (32'(lenq_p1) > 32'(LEN_MAX)) begin
      new_len = LEN_MAX;
    end else begin
      new_len = LEN_W'(lenq_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf    <= 1'b0;
      ncount <= CW'(1);
      tlen   <= '0;
      dcount <= '0;
      last   <= '0;
      row_r  <= '0;
      k      <= '0;
      mnode  <= '0;
      mlen   <= '0;
      mbest  <= '0;
      alive  <= 1'b1;
      first  <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          op_r  <= op;
          sym_r <= symbol;
          rs_r  <= restart;
          ovf   <= 1'b0;
        end
        CMD_REFUSE: ovf <= 1'b1;
        CMD_APP_INIT: begin
          u       <= nc_node;
          row_r   <= nc_node;
          ncount  <= ncount + CW'(1);
          k       <= '0;
          p       <= last;
          cl      <= '0;
          lenlink <= '0;
        end
        CMD_ROOT_CLR, CMD_CLR: k <= k + KW'(1);
        CMD_SETU: lenu <= len_q + TW'(1);
        CMD_WEV: begin
          if (stat.hit) begin
            q    <= trans_q;
            lenp <= len_q;
          end else if (!stat.p_root) begin
            p <= link_q;
          end
        end
        CMD_CKEV: begin
          if (stat.solid) begin
            lenlink <= len_q;
          end else begin
            cl      <= nc_node;
            ncount  <= ncount + CW'(1);
            lenlink <= lenp + TW'(1);
            k       <= '0;
          end
        end
        CMD_COPY: k <= k + KW'(1);
        CMD_REV: if (stat.same && !stat.p_root) p <= link_q;
        CMD_FIN: begin
          last   <= u;
          tlen   <= tlen + TW'(1);
          dcount <= (dsum > {1'b0, CNT_MAX}) ? CNT_MAX : dsum[CNT_W-1:0];
        end
        CMD_M_INIT: begin
          first <= 1'b1;
          p     <= rs_r ? '0 : mnode;
          if (!stat.sym_ok) begin
            mnode <= '0;
            mlen  <= '0;
            alive <= 1'b0;
            if (rs_r) mbest <= '0;
          end else if (rs_r) begin
            mnode <= '0;
            mlen  <= '0;
            mbest <= '0;
            alive <= 1'b1;
          end
        end
        CMD_MEV: begin
          first <= 1'b0;
          if (stat.hit) begin
            mnode <= trans_q;
            mlen  <= new_len;
            if (new_len > mbest) mbest <= new_len;
          end else begin
            alive <= 1'b0;
            if (stat.p_root) begin
              mnode <= '0;
              mlen  <= '0;
            end else begin
              p <= link_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign matched_len    = mlen;
  assign best_len       = mbest;
  assign contained      = alive;
  assign distinct_count = dcount;
  assign overflow       = ovf;

  a_node_cap: assert property (@(posedge clk) disable iff (rst)
    ncount <= CW'(MAX_NODES))
    else $error("node count past capacity");

  a_text_cap: assert property (@(posedge clk) disable iff (rst)
    tlen <= TW'(MAX_TEXT))
    else $error("text length past capacity");

  a_best_ge: assert property (@(posedge clk) disable iff (rst)
    mbest >= mlen)
    else $error("best length below matched length");

  a_fin_delta: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_FIN |-> lenu > lenlink)
    else $error("new node not longer than its link");

  a_clone_order: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_CKEV && !stat.solid |=> cmd == CMD_COPY && k == '0)
    else $error("clone not followed by row copy");

endmodule

### hdl/suffix_automaton_builder_matcher.sv
// append word: clears the new node's row, then walks suffix links adding edges; a hit adds a check,
//   a clone adds a row copy, a redirect walk along suffix links and the link writes for q and the new node
// match word: reads the edge, falling back along suffix links on a miss
// refused or out-of-alphabet word: finishes at dispatch; one word at a time, done pulses for one cycle
// results cannot be stalled; after rst busy is high while the root row is cleared
module suffix_automaton_builder_matcher
  import sam_pkg::*;
#(
  parameter int MAX_TEXT  = DEF_MAX_TEXT,
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int ALPHABET  = DEF_ALPHABET
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             op,
  input  logic [SYM_W-1:0] symbol,
  input  logic             restart,
  output logic             busy,
  output logic             done,
  output logic [LEN_W-1:0] matched_len,
  output logic [LEN_W-1:0] best_len,
  output logic             contained,
  output logic [CNT_W-1:0] distinct_count,
  output logic             overflow
);

  cmd_t      cmd;
  sam_stat_t stat;

  sam_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  sam_dpath #(
    .MAX_TEXT  (MAX_TEXT),
    .MAX_NODES (MAX_NODES),
    .ALPHABET  (ALPHABET)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (op),
    .symbol         (symbol),
    .restart        (restart),
    .stat           (stat),
    .matched_len    (matched_len),
    .best_len       (best_len),
    .contained      (contained),
    .distinct_count (distinct_count),
    .overflow       (overflow)
  );

endmodule

### test/tb_suffix_automaton_builder_matcher.sv
module tb_suffix_automaton_builder_matcher;
  import sam_pkg::*;

  localparam int NTEXT  = DEF_MAX_TEXT;
  localparam int NNODES = DEF_MAX_NODES;
  localparam int NSYM   = DEF_ALPHABET;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic             op;
    logic [SYM_W-1:0] symbol;
    logic             restart;
  } word_t;

  typedef struct {
    logic [LEN_W-1:0] matched_len;
    logic [LEN_W-1:0] best_len;
    logic             contained;
    logic [CNT_W-1:0] distinct_count;
    logic             overflow;
  } answer_t;

  logic             clk = 0;
  logic             rst = 1;
  logic             start = 0;
  logic             op = OP_APPEND;
  logic [SYM_W-1:0] symbol = '0;
  logic             restart = 0;
  logic             busy, done, contained, overflow;
  logic [LEN_W-1:0] matched_len, best_len;
  logic [CNT_W-1:0] distinct_count;

  suffix_automaton_builder_matcher dut (.*);

  always #2 clk = ~clk;

  // automaton model
  int unsigned edge_to [NNODES*NSYM];
  int unsigned slink [NNODES];
  int unsigned nlen [NNODES];
  int unsigned tail_node = 0, nodes = 1, text_len = 0, distinct = 0;
  int unsigned walk_node = 0, walk_len = 0, walk_best = 0;
  bit          walk_alive = 1;

  word_t   pending [$];
  answer_t awaited [$];
  int      errors = 0;
  int      gap_left = 0;
  bit      calm = 0;
  int      cycles = 0;

  function automatic bit extend_text(int unsigned d);
    int unsigned u, p, q, cl;
    bit hit_root;
    hit_root = 0;
    if (text_len >= NTEXT || nodes + 2 > NNODES) return 0;
    u = nodes++;
    for (int i = 0; i < NSYM; i++) edge_to[u*NSYM+i] = 0;
    nlen[u] = nlen[tail_node] + 1;
    slink[u] = 0;
    p = tail_node;
    forever begin
      if (edge_to[p*NSYM+d] != 0) break;
      edge_to[p*NSYM+d] = u;
      if (p == 0) begin
        hit_root = 1;
        break;
      end
      p = slink[p];
    end
    if (!hit_root) begin
      q = edge_to[p*NSYM+d];
      if (nlen[p] + 1 == nlen[q]) slink[u] = q;
      else begin
        cl = nodes++;
        nlen[cl] = nlen[p] + 1;
        for (int i = 0; i < NSYM; i++) edge_to[cl*NSYM+i] = edge_to[q*NSYM+i];
        slink[cl] = slink[q];
        forever begin
          if (edge_to[p*NSYM+d] != q) break;
          edge_to[p*NSYM+d] = cl;
          if (p == 0) break;
          p = slink[p];
        end
        slink[q] = cl;
        slink[u] = cl;
      end
    end
    tail_node = u;
    text_len++;
    distinct += nlen[u] - nlen[slink[u]];
    if (distinct > CNT_MAX) distinct = CNT_MAX;
    return 1;
  endfunction

  function automatic void walk_query(int unsigned d, bit ok);
    int unsigned t, v;
    t = ok ? edge_to[walk_node*NSYM+d] : 0;
    if (t != 0) begin
      walk_node = t;
      if (walk_len < LEN_MAX) walk_len++;
    end else begin
      walk_alive = 0;
      v = walk_node;
      forever begin
        if (ok && edge_to[v*NSYM+d] != 0) begin
          walk_len = nlen[v] + 1;
          if (walk_len > LEN_MAX) walk_len = LEN_MAX;
          walk_node = edge_to[v*NSYM+d];
          break;
        end
        if (v == 0) begin
          walk_len = 0;
          walk_node = 0;
          break;
        end
        v = slink[v];
      end
    end
    if (walk_len > walk_best) walk_best = walk_len;
  endfunction

  function automatic answer_t predict_answer(word_t w);
    answer_t a;
    bit ok;
    ok = w.symbol < NSYM;
    a.overflow = 0;
    if (w.op == OP_APPEND) begin
      if (ok && !extend_text(w.symbol)) a.overflow = 1;
    end else begin
      if (w.restart) begin
        walk_node = 0;
        walk_len = 0;
        walk_best = 0;
        walk_alive = 1;
      end
      walk_query(w.symbol, ok);
    end
    a.matched_len = LEN_W'(walk_len);
    a.best_len = LEN_W'(walk_best);
    a.contained = walk_alive;
    a.distinct_count = CNT_W'(distinct);
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic report(string field, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    bit fire;
    word_t w;
    if (!rst) begin
      fire = start && !busy;
      if (fire) begin
        w = pending.pop_front();
        awaited = {awaited, predict_answer(w)};
        if ($urandom_range(99) == 0) calm = ~calm;
        gap_left = pick_gap();
      end
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 0;
        end else if (pending.size() > 0) begin
          op <= pending[0].op;
          symbol <= pending[0].symbol;
          restart <= pending[0].restart;
          start <= 1;
        end else begin
          start <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t a;
    if (!rst && done) begin
      if (awaited.size() == 0) report("unexpected word", 1, 0);
      else begin
        a = awaited.pop_front();
        if (matched_len !== a.matched_len) report("matched_len", matched_len, a.matched_len);
        if (best_len !== a.best_len) report("best_len", best_len, a.best_len);
        if (contained !== a.contained) report("contained", contained, a.contained);
        if (distinct_count !== a.distinct_count)
          report("distinct_count", distinct_count, a.distinct_count);
        if (overflow !== a.overflow) report("overflow", overflow, a.overflow);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[suffix_automaton_builder_matcher] ERROR");
      $finish;
    end
  end

  int unsigned gen_text [$];

  task automatic add_word(logic o, int unsigned s, logic r);
    word_t w;
    w.op = o;
    w.symbol = SYM_W'(s);
    w.restart = r;
    pending = {pending, w};
    if (o == OP_APPEND && s < NSYM && gen_text.size() < NTEXT) gen_text = {gen_text, s};
  endtask

  task automatic add_query();
    int n, b;
    if (gen_text.size() == 0) return;
    n = $urandom_range(gen_text.size() < 8 ? gen_text.size() : 8, 1);
    b = $urandom_range(gen_text.size() - n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) add_word(OP_MATCH, $urandom_range(31), i == 0);
      else add_word(OP_MATCH, gen_text[b+i], i == 0);
    end
  endtask

  initial begin
    int alpha, r, it;
    string seed;
    seed = "aabab";
    // empty text, out of range symbols, clones, fallback
    add_word(OP_MATCH, 0, 1);
    add_word(OP_APPEND, 31, 0);
    add_word(OP_MATCH, 26, 0);
    foreach (seed[i]) add_word(OP_APPEND, seed[i] - "a", 0);
    add_word(OP_APPEND, 1, 1);
    add_word(OP_APPEND, 26, 0);
    add_word(OP_APPEND, 25, 0);
    add_word(OP_MATCH, 0, 1);
    add_word(OP_MATCH, 1, 0);
    add_word(OP_MATCH, 1, 0);
    add_word(OP_MATCH, 1, 0);
    add_word(OP_MATCH, 25, 0);
    add_word(OP_MATCH, 27, 0);
    add_word(OP_MATCH, 31, 0);
    add_word(OP_APPEND, 0, 0);
    add_word(OP_MATCH, 0, 0);
    add_word(OP_MATCH, 25, 1);
    add_word(OP_MATCH, 16, 0);

    // grow the text to capacity with queries and odd words mixed in
    alpha = 3;
    it = 0;
    while (gen_text.size() < NTEXT) begin
      r = $urandom_range(99);
      if (it % 150 == 0) alpha = $urandom_range(NSYM, 2);
      it++;
      if (r < 92) begin
        add_word(OP_APPEND, $urandom_range(alpha - 1), 1'($urandom_range(1)));
      end else if (r < 97) begin
        add_query();
      end else begin
        add_word(1'($urandom_range(1)), $urandom_range(31), 1'($urandom_range(1)));
      end
    end
    // refused appends and queries on the full text
    for (int i = 0; i < 6; i++) add_word(OP_APPEND, $urandom_range(NSYM - 1), 0);
    for (int i = 0; i < 6; i++) add_query();

    repeat (3) @(posedge clk);
    rst <= 0;
    wait (pending.size() == 0 && awaited.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && awaited.size() == 0) begin
      $display("[suffix_automaton_builder_matcher] OK");
    end else begin
      $display("[suffix_automaton_builder_matcher] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/sam_pkg.sv
hdl/sam_ctrl.sv
hdl/sam_dpath.sv
hdl/suffix_automaton_builder_matcher.sv
test/tb_suffix_automaton_builder_matcher.sv
